// ===== hdl/gptnm_pkg.sv =====
`default_nettype none
package gptnm_pkg;

  // note store geometry
  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int OFF_W      = 7;
  localparam int STEP_W     = 7;

  // layout generations (host_model / derived client model)
  localparam logic [1:0] MODEL_NONE = 2'd0;
  localparam logic [1:0] MODEL_GEN1 = 2'd1;
  localparam logic [1:0] MODEL_GEN2 = 2'd2;
  localparam logic [1:0] MODEL_GEN3 = 2'd3;

  // status nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_CTRL     = 4'hB;

  // arrow controller numbers per layout
  localparam logic [6:0] G1_UP = 7'd104, G1_DOWN = 7'd105, G1_LEFT = 7'd106, G1_RIGHT = 7'd107;
  localparam logic [6:0] G2_UP = 7'd91,  G2_DOWN = 7'd92,  G2_LEFT = 7'd93,  G2_RIGHT = 7'd94;
  localparam logic [6:0] G3_UP = 7'd80,  G3_DOWN = 7'd79,  G3_LEFT = 7'd91,  G3_RIGHT = 7'd92;

  // pad key ranges
  localparam logic [6:0] KEY_LO_G1 = 7'd11;
  localparam logic [6:0] KEY_LO_G2 = 7'd10;
  localparam logic [6:0] KEY_LO_G3 = 7'd11;
  localparam logic [6:0] KEY_HI    = 7'd89;

  // offset limits for each arrow
  localparam logic [6:0] OFF_UP_MAX    = 7'd123;
  localparam logic [6:0] OFF_DOWN_MIN  = 7'd4;
  localparam logic [6:0] OFF_LEFT_MIN  = 7'd3;
  localparam logic [6:0] OFF_RIGHT_MAX = 7'd124;

  // pad colour classes
  localparam logic [1:0] CLS_ACCIDENTAL = 2'd0;
  localparam logic [1:0] CLS_C          = 2'd1;
  localparam logic [1:0] CLS_NATURAL    = 2'd2;
  localparam logic [1:0] CLS_HELD       = 2'd3;

  typedef enum logic [2:0] {
    ARW_NONE,
    ARW_UP,
    ARW_DOWN,
    ARW_LEFT,
    ARW_RIGHT
  } arrow_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              is_query;
    logic              has_src;
    logic [1:0]        src;       // 0 host, 1..3 client cable 0..2
    logic              pad;
    logic [STEP_W-1:0] step;      // col*3 + row*4
    arrow_t            arrow;
    logic [VEL_W-1:0]  value;
    logic              show_held;
  } cmd_t;

  typedef struct packed {
    logic             note_valid;
    logic [7:0]       mapped_note;
    logic [1:0]       pad_class;
    logic [OFF_W-1:0] offset_now;
    logic             changed;
    logic             notes_cleared;
  } result_t;

  // col*3 + row*4, col up to 16, row up to 8
  function automatic logic [STEP_W-1:0] grid_step(input logic [4:0] col, input logic [3:0] row);
    logic [STEP_W-1:0] c3;
    logic [STEP_W-1:0] r4;
    c3 = {2'b00, col} * 7'd3;
    r4 = {1'b0, row, 2'b00};
    return c3 + r4;
  endfunction

  // pitch class color; note/12 by reciprocal 171/2048, exact for 8-bit notes
  function automatic logic [1:0] class_of(input logic [7:0] note);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  q12;
    logic [7:0]  r;
    logic [1:0]  cls;
    prod = {8'd0, note} * 16'd171;
    q    = prod[15:11];
    q12  = {3'd0, q} * 8'd12;
    r    = note - q12;
    case (r[3:0])
      4'd0:                              cls = CLS_C;
      4'd1, 4'd3, 4'd6, 4'd8, 4'd10:     cls = CLS_ACCIDENTAL;
      default:                           cls = CLS_NATURAL;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gptnm_ram.sv =====
`default_nettype none
module gptnm_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gptnm_front.sv =====
`default_nettype none
module gptnm_front
  import gptnm_pkg::*;
(
  input  wire logic       action,
  input  wire logic       from_host,
  input  wire logic [3:0] cable_number,
  input  wire logic [7:0] status_byte,
  input  wire logic [6:0] key_number,
  input  wire logic [6:0] key_value,
  input  wire logic [1:0] query_source,
  input  wire logic [2:0] query_row,
  input  wire logic [3:0] query_column,
  input  wire logic       query_show_held,
  input  wire logic [1:0] host_model,
  output      cmd_t       cmd
);

  logic        client_ok;
  logic [1:0]  model;
  logic [3:0]  kind;
  logic        pad_msg;
  logic [14:0] prod10;
  logic [3:0]  key_div10;
  logic [6:0]  div10x;
  logic [3:0]  key_mod10;
  logic        pad;
  logic [4:0]  col;
  logic [3:0]  row;
  logic [6:0]  up_key, down_key, left_key, right_key;
  arrow_t      arrow;

  assign client_ok = (cable_number < 4'd3);
  assign kind      = status_byte[7:4];
  assign pad_msg   = (kind >= ST_NOTE_OFF) && (kind <= ST_CTRL);

  // source layout: host register, or cable number plus one
  always_comb begin
    if (from_host) begin
      model = host_model;
    end else if (client_ok) begin
      model = cable_number[1:0] + 2'd1;
    end else begin
      model = MODEL_NONE;
    end
  end

  // key / 10 as (key*205)>>11, exact over 0..127
  assign prod10    = {8'd0, key_number} * 15'd205;
  assign key_div10 = prod10[14:11];
  assign div10x    = {3'd0, key_div10} * 7'd10;
  assign key_mod10 = 4'(key_number - div10x);

  // pad key to grid column and row
  always_comb begin
    pad = 1'b0;
    col = '0;
    row = '0;
    if (pad_msg) begin
      case (model)
        MODEL_GEN1: begin
          if (key_number >= KEY_LO_G1 && key_number <= KEY_HI) begin
            pad = 1'b1;
            col = {1'b0, key_number[3:0]} + 5'd1;
            row = 4'd7 - {1'b0, key_number[6:4]};
          end
        end
        MODEL_GEN2: begin
          if (key_number >= KEY_LO_G2 && key_number <= KEY_HI) begin
            pad = 1'b1;
            col = {1'b0, key_mod10};
            row = key_div10 - 4'd1;
          end
        end
        MODEL_GEN3: begin
          if (key_number >= KEY_LO_G3 && key_number <= KEY_HI) begin
            pad = 1'b1;
            col = {1'b0, key_mod10};
            row = key_div10;
          end
        end
        default: ;
      endcase
    end
  end

  // arrow controls of the layout
  always_comb begin
    case (model)
      MODEL_GEN1: begin
        up_key = G1_UP; down_key = G1_DOWN; left_key = G1_LEFT; right_key = G1_RIGHT;
      end
      MODEL_GEN2: begin
        up_key = G2_UP; down_key = G2_DOWN; left_key = G2_LEFT; right_key = G2_RIGHT;
      end
      default: begin
        up_key = G3_UP; down_key = G3_DOWN; left_key = G3_LEFT; right_key = G3_RIGHT;
      end
    endcase
    arrow = ARW_NONE;
    if (model != MODEL_NONE && kind == ST_CTRL && key_value != '0) begin
      if (key_number == up_key) begin
        arrow = ARW_UP;
      end else if (key_number == down_key) begin
        arrow = ARW_DOWN;
      end else if (key_number == left_key) begin
        arrow = ARW_LEFT;
      end else if (key_number == right_key) begin
        arrow = ARW_RIGHT;
      end
    end
  end

  // build the request
  always_comb begin
    cmd.value     = key_value;
    cmd.show_held = query_show_held;
    if (action) begin
      cmd.is_query = 1'b1;
      cmd.has_src  = 1'b1;
      cmd.src      = query_source;
      cmd.pad      = 1'b0;
      cmd.step     = grid_step({1'b0, query_column}, {1'b0, query_row});
      cmd.arrow    = ARW_NONE;
    end else begin
      cmd.is_query = 1'b0;
      cmd.has_src  = from_host || client_ok;
      cmd.src      = from_host ? 2'd0 : (cable_number[1:0] + 2'd1);
      cmd.pad      = pad;
      cmd.step     = grid_step(col, row);
      cmd.arrow    = arrow;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gptnm_queue.sv =====
`default_nettype none
module gptnm_queue
  import gptnm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output      logic push_ready,
  input  wire cmd_t push_data,
  output      logic pop_valid,
  input  wire logic pop_ready,
  output      cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gptnm_back.sv =====
`default_nettype none
module gptnm_back
  import gptnm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  output      logic    cmd_ready,
  input  wire cmd_t    cmd,
  output      logic    res_valid,
  input  wire logic    res_ready,
  output      result_t res
);

  logic [OFF_W-1:0]      offsets [4];
  logic [NOTE_COUNT-1:0] held_valid;
  logic [NOTE_COUNT-1:0] held_valid_next;

  logic [OFF_W-1:0]  off;
  logic [7:0]        tuned;
  logic              in_range;
  logic [NOTE_W-1:0] addr;
  logic              store;
  logic              move;
  logic [OFF_W-1:0]  new_off;
  logic              held_chk;
  logic              a_fire;

  // result register
  logic              b_valid;
  result_t           b_res;
  logic              b_held_chk;
  logic [VEL_W-1:0]  vel_rd;

  assign cmd_ready = !b_valid || res_ready;
  assign a_fire    = cmd_valid && cmd_ready;

  // note arithmetic on the head request
  assign off      = offsets[cmd.src];
  assign tuned    = {1'b0, off} + {1'b0, cmd.step};
  assign in_range = !tuned[7];
  assign addr     = tuned[NOTE_W-1:0];
  assign store    = !cmd.is_query && cmd.pad && in_range;
  assign held_chk = cmd.is_query && cmd.show_held && in_range && held_valid[addr];

  // arrow step within limits
  always_comb begin
    move    = 1'b0;
    new_off = off;
    case (cmd.arrow)
      ARW_UP: begin
        if (off <= OFF_UP_MAX) begin
          move = 1'b1; new_off = off + 7'd4;
        end
      end
      ARW_DOWN: begin
        if (off >= OFF_DOWN_MIN) begin
          move = 1'b1; new_off = off - 7'd4;
        end
      end
      ARW_LEFT: begin
        if (off >= OFF_LEFT_MIN) begin
          move = 1'b1; new_off = off - 7'd3;
        end
      end
      ARW_RIGHT: begin
        if (off <= OFF_RIGHT_MAX) begin
          move = 1'b1; new_off = off + 7'd3;
        end
      end
      default: ;
    endcase
  end

  // held flags: a clear wins over a store in the same request
  always_comb begin
    held_valid_next = held_valid;
    if (a_fire) begin
      if (move) begin
        held_valid_next = '0;
      end else if (store) begin
        held_valid_next[addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= '0;
      for (int i = 0; i < 4; i++) begin
        offsets[i] <= '0;
      end
    end else begin
      held_valid <= held_valid_next;
      if (a_fire && move) begin
        offsets[cmd.src] <= new_off;
      end
    end
  end

  // velocity store
  gptnm_ram #(
    .WIDTH(VEL_W),
    .DEPTH(NOTE_COUNT)
  ) u_vel_ram (
    .clk  (clk),
    .we   (a_fire && store),
    .waddr(addr),
    .wdata(cmd.value),
    .re   (a_fire && held_chk),
    .raddr(addr),
    .rdata(vel_rd)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cmd_ready) begin
      b_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_res.note_valid    <= cmd.is_query ? in_range : store;
      b_res.mapped_note   <= (cmd.is_query || cmd.pad) ? tuned : 8'd0;
      b_res.pad_class     <= cmd.is_query ? class_of(tuned) : CLS_ACCIDENTAL;
      b_res.offset_now    <= cmd.has_src ? new_off : '0;
      b_res.changed       <= store || move;
      b_res.notes_cleared <= move;
      b_held_chk          <= held_chk;
    end
  end

  // a held note with nonzero velocity overrides the pitch class
  always_comb begin
    res = b_res;
    if (b_held_chk && vel_rd != '0) begin
      res.pad_class = CLS_HELD;
    end
  end
  assign res_valid = b_valid;

  // a moved offset leaves no held note behind
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    a_fire && move |=> held_valid == '0)
    else $error("held flags not cleared after offset move");

  // a store without a move marks its note held
  a_store_mark: assert property (@(posedge clk) disable iff (rst)
    a_fire && store && !move |=> held_valid[$past(addr)])
    else $error("stored note not marked held");

  // a valid note is always inside the store
  a_note_range: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_res.note_valid |-> !b_res.mapped_note[7])
    else $error("valid note out of range");

  // a clear is always reported as a change
  a_clear_changed: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_res.notes_cleared |-> b_res.changed)
    else $error("clear without change flag");

endmodule
`default_nettype wire

// ===== hdl/grid_pad_tonnetz_note_mapper_top.sv =====
`default_nettype none
// A request passes through a queue slot and then the back result register to m_tvalid.
// Throughput: one request per cycle sustained while m_tready is high; the offset update
//   and held-flag write are both registered when the back stage accepts a request.
// The request queue (QUEUE_DEPTH entries) lets front and back stall independently.
// Reset (rst, synchronous): host_model, offsets, held flags, queue and result
//   valid clear; the velocity RAM is not swept, its reads are gated by held flags.
module grid_pad_tonnetz_note_mapper_top
  import gptnm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // [0] from_host, [4:1] cable_number, [12:5] status_byte, [19:13] key_number,
  // [26:20] key_value, [28:27] query_source, [31:29] query_row,
  // [35:32] query_column, [36] query_show_held, [39:37] zero
  input  wire logic [39:0] s_tdata,
  // [0] action
  input  wire logic        s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [0] note_valid, [8:1] mapped_note, [10:9] pad_class, [17:11] offset_now,
  // [18] changed, [19] notes_cleared, [23:20] zero
  output      logic [23:0] m_tdata
);

  logic [1:0] host_model;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       head_valid;
  logic       head_ready;
  result_t    res;

  // host layout register
  always_ff @(posedge clk) begin
    if (rst) begin
      host_model <= MODEL_NONE;
    end else if (cfg_wen) begin
      host_model <= cfg_wdata;
    end
  end

  gptnm_front u_front (
    .action         (s_tuser),
    .from_host      (s_tdata[0]),
    .cable_number   (s_tdata[4:1]),
    .status_byte    (s_tdata[12:5]),
    .key_number     (s_tdata[19:13]),
    .key_value      (s_tdata[26:20]),
    .query_source   (s_tdata[28:27]),
    .query_row      (s_tdata[31:29]),
    .query_column   (s_tdata[35:32]),
    .query_show_held(s_tdata[36]),
    .host_model     (host_model),
    .cmd            (front_cmd)
  );

  gptnm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(s_tvalid),
    .push_ready(s_tready),
    .push_data (front_cmd),
    .pop_valid (head_valid),
    .pop_ready (head_ready),
    .pop_data  (head_cmd)
  );

  gptnm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd_ready(head_ready),
    .cmd      (head_cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  // result packing
  assign m_tdata = {4'd0, res.notes_cleared, res.changed, res.offset_now,
                    res.pad_class, res.mapped_note, res.note_valid};

endmodule
`default_nettype wire
